FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// combinational invariant checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/core/amcd_pkg.sv
// ----------------------------------------------------------------------------
// amcd_pkg
// Shared types, codes and helper functions of the motor command decoder
// ----------------------------------------------------------------------------
package amcd_pkg;

	localparam int LINE_MAX_DEF = 128;

	typedef enum logic [3:0] {
		KIND_START     = 4'd0,
		KIND_STOP      = 4'd1,
		KIND_SET_SPEED = 4'd2,
		KIND_INFO      = 4'd3,
		KIND_HOME      = 4'd4,
		KIND_MOVE      = 4'd5,
		KIND_BAD_MOTOR = 4'd6,
		KIND_UNKNOWN   = 4'd7,
		KIND_OVERFLOW  = 4'd8
	} cmd_kind_t;

	// keyword flag positions
	localparam int KW_START = 0;
	localparam int KW_STOP  = 1;
	localparam int KW_SET   = 2;
	localparam int KW_INFO  = 3;
	localparam int KW_HOME  = 4;
	localparam int KW_M     = 5;

	localparam logic [5:0] ALL_ALIVE = 6'h3F;

	// keyword text, right-aligned, first character in the highest used byte
	localparam logic [79:0] KW_START_STR = "START";
	localparam logic [79:0] KW_STOP_STR  = "STOP";
	localparam logic [79:0] KW_SET_STR   = "SET SPEED ";
	localparam logic [79:0] KW_INFO_STR  = "INFO";
	localparam logic [79:0] KW_HOME_STR  = "HOME";

	localparam logic [3:0] KW_START_LEN = 4'd5;
	localparam logic [3:0] KW_STOP_LEN  = 4'd4;
	localparam logic [3:0] KW_SET_LEN   = 4'd10;
	localparam logic [3:0] KW_INFO_LEN  = 4'd4;
	localparam logic [3:0] KW_HOME_LEN  = 4'd4;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_ONE   = 8'd49;
	localparam logic [7:0] CH_THREE = 8'd51;
	localparam logic [7:0] CH_M     = 8'd77;

	// magnitude cap and steps for it: 2^31*5 = 9*CAP_Q + CAP_R
	localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
	localparam logic [30:0] CAP_Q     = 31'd1193046471;
	localparam logic [3:0]  CAP_R     = 4'd1;
	localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] STEPS_MAX = 32'd1193046470;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} num_phase_t;

	// number parser state; q and r hold acc*5 = 9*q + r
	typedef struct packed {
		logic        neg;
		num_phase_t  phase;
		logic [31:0] acc;
		logic [30:0] q;
		logic [3:0]  r;
	} num_t;

	localparam num_t NUM_CLEAR = '{neg: 1'b0, phase: PH_SKIP, acc: 32'd0, q: 31'd0, r: 4'd0};

	function automatic logic [7:0] kw_char(logic [79:0] kw, logic [3:0] len, logic [3:0] i);
		logic [7:0] c;
		c = 8'd0;
		if (i < len) begin
			c = kw[8 * (int'(len) - 1 - int'(i)) +: 8];
		end
		return c;
	endfunction

	function automatic logic is_space(logic [7:0] ch);
		return (ch == CH_SPACE) || ((ch >= 8'd9) && (ch <= CH_CR));
	endfunction

	function automatic logic is_digit(logic [7:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

	function automatic num_t num_feed(num_t n, logic [7:0] ch);
		num_t        r;
		logic [3:0]  d;
		logic [31:0] acc_b;
		logic [30:0] q_b;
		logic [3:0]  r_b;
		logic [35:0] t;
		logic [6:0]  x;
		logic [13:0] prod;
		logic [3:0]  qa;
		logic [6:0]  rr;
		logic [34:0] qn;
		r     = n;
		d     = ch[3:0];
		acc_b = (n.phase == PH_DIGITS) ? n.acc : 32'd0;
		q_b   = (n.phase == PH_DIGITS) ? n.q : 31'd0;
		r_b   = (n.phase == PH_DIGITS) ? n.r : 4'd0;
		t     = {1'b0, acc_b, 3'b0} + {3'b0, acc_b, 1'b0} + {32'd0, d};
		// carry of 10*r + 5*d over 9, divided by reciprocal
		x     = {r_b, 3'b0} + {2'b0, r_b, 1'b0} + {1'b0, d, 2'b0} + {3'b0, d};
		prod  = {7'd0, x} * 14'd57;
		qa    = prod[12:9];
		rr    = x - ({qa, 3'b0} + {3'b0, qa});
		qn    = {1'b0, q_b, 3'b0} + {3'b0, q_b, 1'b0} + {31'd0, qa};
		unique case (n.phase)
			PH_SKIP: begin
				if (is_space(ch)) begin
					r = n;
				end else if (ch == CH_PLUS) begin
					r.phase = PH_DIGITS;
				end else if (ch == CH_MINUS) begin
					r.phase = PH_DIGITS;
					r.neg   = 1'b1;
				end else if (!is_digit(ch)) begin
					r.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (!is_digit(ch)) begin
					r.phase = PH_DONE;
				end
			end
			default: begin
				r = n;
			end
		endcase
		if ((n.phase == PH_SKIP || n.phase == PH_DIGITS) && is_digit(ch)) begin
			r.phase = PH_DIGITS;
			if (t > {4'd0, MAG_CAP}) begin
				r.acc = MAG_CAP;
				r.q   = CAP_Q;
				r.r   = CAP_R;
			end else begin
				r.acc = t[31:0];
				r.q   = qn[30:0];
				r.r   = rr[3:0];
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] num_value(num_t n);
		logic [31:0] v;
		if (n.neg) begin
			v = ~n.acc + 32'd1;
		end else if (n.acc > POS_MAX) begin
			v = POS_MAX;
		end else begin
			v = n.acc;
		end
		return v;
	endfunction

	function automatic logic [31:0] num_steps(num_t n);
		logic [31:0] s;
		if (n.neg) begin
			s = ~{1'b0, n.q} + 32'd1;
		end else if (n.acc > POS_MAX) begin
			s = STEPS_MAX;
		end else begin
			s = {1'b0, n.q};
		end
		return s;
	endfunction

endpackage

FILE: rtl/core/ascii_motor_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// ascii_motor_command_decoder_unit
// Parses serial text bytes into motor commands, one result per line feed or per overflow of the line
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)                     transfer
// s_axis    in   rx_byte[7:0]                                  one byte
// m_axis    out  command_kind, motor_number, number_value,     one command
//                step_count, zero pad to 72 bits
//
// one byte per cycle while no stalled result holds the input register
// a line feed or overflow byte there has its result registered onto m_axis
// arst_n clears the line state and both valid flags
// a stalled result blocks only a byte that gives another result; that byte
// then waits in the input register and holds back the bytes behind it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_motor_command_decoder_unit
	import amcd_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // command_kind[3:0], motor_number[5:4],
	                                   // number_value[37:6], step_count[69:38]
);

	localparam int LPW = $clog2(LINE_MAX);
	localparam logic [LPW-1:0] POS_LIMIT = LPW'(LINE_MAX - 1);

	typedef struct packed {
		logic [LPW-1:0] tlen;
		logic           ended;
		logic [5:0]     alive;
		logic [7:0]     motor;
		num_t           spd;
		num_t           ang;
	} line_t;

	localparam line_t LINE_CLEAR = '{
		tlen: '0, ended: 1'b0, alive: ALL_ALIVE, motor: 8'd0,
		spd: NUM_CLEAR, ang: NUM_CLEAR
	};

	function automatic logic kw_kill(logic [79:0] kw, logic [3:0] len, logic exact,
		logic [LPW-1:0] idx, logic [7:0] ch);
		logic k;
		if (idx < LPW'(len)) begin
			k = (kw_char(kw, len, idx[3:0]) != ch);
		end else begin
			k = exact;
		end
		return k;
	endfunction

	function automatic line_t text_feed(line_t s, logic [7:0] ch);
		line_t          r;
		logic [LPW-1:0] idx;
		r   = s;
		idx = s.tlen;
		if (!s.ended) begin
			if (ch == CH_NUL) begin
				r.ended = 1'b1;
			end else begin
				r.tlen = s.tlen + LPW'(1);
				if (kw_kill(KW_START_STR, KW_START_LEN, 1'b1, idx, ch)) r.alive[KW_START] = 1'b0;
				if (kw_kill(KW_STOP_STR, KW_STOP_LEN, 1'b1, idx, ch)) r.alive[KW_STOP] = 1'b0;
				if (kw_kill(KW_SET_STR, KW_SET_LEN, 1'b0, idx, ch)) r.alive[KW_SET] = 1'b0;
				if (kw_kill(KW_INFO_STR, KW_INFO_LEN, 1'b0, idx, ch)) r.alive[KW_INFO] = 1'b0;
				if (kw_kill(KW_HOME_STR, KW_HOME_LEN, 1'b0, idx, ch)) r.alive[KW_HOME] = 1'b0;
				if (idx == LPW'(0) && ch != CH_M) r.alive[KW_M] = 1'b0;
				if (idx == LPW'(1)) r.motor = ch;
				if (idx >= LPW'(3)) r.ang = num_feed(s.ang, ch);
				if (idx >= LPW'(10)) r.spd = num_feed(s.spd, ch);
			end
		end
		return r;
	endfunction

	logic [7:0]     byte_s1;
	logic           vld_s1;
	logic [LPW-1:0] line_pos_q;
	logic           pend_cr_q;
	line_t          ln_q;
	logic           m_valid_q;
	cmd_kind_t      kind_q;
	logic [1:0]     motor_q;
	logic [31:0]    value_q;
	logic [31:0]    steps_q;

	logic           is_lf;
	logic           is_ovf;
	logic           gives_res;
	logic           fire;
	line_t          ln_cr;
	line_t          ln_next;
	cmd_kind_t      kind_d;
	logic [1:0]     motor_d;
	logic [31:0]    value_d;
	logic [31:0]    steps_d;

	assign is_lf     = (byte_s1 == CH_LF);
	assign is_ovf    = !is_lf && (line_pos_q >= POS_LIMIT);
	assign gives_res = is_lf || is_ovf;
	assign fire      = vld_s1 && (!gives_res || !m_valid_q || m_axis_tready);

	assign s_axis_tready = !vld_s1 || fire;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, steps_q, value_q, motor_q, kind_q};

	// held carriage return goes in first, then the new byte; a new CR is held
	always_comb begin
		ln_cr   = pend_cr_q ? text_feed(ln_q, CH_CR) : ln_q;
		ln_next = (byte_s1 == CH_CR) ? ln_cr : text_feed(ln_cr, byte_s1);
	end

	always_comb begin
		kind_d  = KIND_UNKNOWN;
		motor_d = 2'd0;
		value_d = 32'd0;
		steps_d = 32'd0;
		if (is_ovf) begin
			kind_d = KIND_OVERFLOW;
		end else priority if (ln_q.alive[KW_START] && ln_q.tlen == LPW'(5)) begin
			kind_d = KIND_START;
		end else if (ln_q.alive[KW_STOP] && ln_q.tlen == LPW'(4)) begin
			kind_d = KIND_STOP;
		end else if (ln_q.alive[KW_SET] && ln_q.tlen >= LPW'(10)) begin
			kind_d  = KIND_SET_SPEED;
			value_d = num_value(ln_q.spd);
		end else if (ln_q.alive[KW_INFO] && ln_q.tlen >= LPW'(4)) begin
			kind_d = KIND_INFO;
		end else if (ln_q.alive[KW_HOME] && ln_q.tlen >= LPW'(4)) begin
			kind_d = KIND_HOME;
		end else if (ln_q.alive[KW_M] && ln_q.tlen >= LPW'(1)) begin
			if (ln_q.motor >= CH_ONE && ln_q.motor <= CH_THREE) begin
				kind_d  = KIND_MOVE;
				motor_d = ln_q.motor[1:0];
				value_d = num_value(ln_q.ang);
				steps_d = num_steps(ln_q.ang);
			end else begin
				kind_d = KIND_BAD_MOTOR;
			end
		end else begin
			kind_d = KIND_UNKNOWN;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (fire && gives_res) begin
			kind_q  <= kind_d;
			motor_q <= motor_d;
			value_q <= value_d;
			steps_q <= steps_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			m_valid_q  <= 1'b0;
			line_pos_q <= '0;
			pend_cr_q  <= 1'b0;
			ln_q       <= LINE_CLEAR;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire && gives_res) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (fire) begin
				if (gives_res) begin
					line_pos_q <= '0;
					pend_cr_q  <= 1'b0;
					ln_q       <= LINE_CLEAR;
				end else begin
					line_pos_q <= line_pos_q + LPW'(1);
					pend_cr_q  <= (byte_s1 == CH_CR);
					ln_q       <= ln_next;
				end
			end
		end
	end

	`ASSERT_ALWAYS(a_tlen_le_pos, clk, arst_n, ln_q.tlen <= line_pos_q, "text longer than line")
	`ASSERT_ALWAYS(a_cr_in_line, clk, arst_n, !pend_cr_q || line_pos_q != '0, "held cr in empty line")
	`ASSERT_PROP(a_res_follows, clk, arst_n, fire && gives_res |=> m_valid_q, "result not registered")
	`ASSERT_ALWAYS(a_motor_move, clk, arst_n, !m_valid_q || ((kind_q == KIND_MOVE) == (motor_q != 2'd0)), "motor field mismatch")
	`ASSERT_ALWAYS(a_steps_move, clk, arst_n, !m_valid_q || kind_q == KIND_MOVE || steps_q == 32'd0, "steps outside move")

endmodule

FILE: tb/ascii_motor_command_checker.sv
// ----------------------------------------------------------------------------
// ascii_motor_command_checker
// Watches both stream channels of the motor command decoder, rebuilds the
// line parse byte by byte, and compares every command transfer in order
// ----------------------------------------------------------------------------
module ascii_motor_command_checker
	import amcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte[7:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,  // command_kind[3:0], motor_number[5:4],
	                                   // number_value[37:6], step_count[69:38]
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output logic [8:0]  kinds_seen
);

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic        neg;
		num_phase_t  phase;
		logic [31:0] mag;
	} atoi_t;

	typedef struct {
		cmd_kind_t   kind;
		logic [1:0]  motor;
		logic [31:0] value;
		logic [31:0] steps;
	} command_t;

	string       keywords [5] = '{"START", "STOP", "SET SPEED ", "INFO", "HOME"};
	command_t    expected_commands [$];
	int unsigned line_len;
	int unsigned text_len;
	logic        text_done;
	logic        cr_held;
	logic [5:0]  alive;
	logic [7:0]  motor_ch;
	atoi_t       speed_num;
	atoi_t       angle_num;
	int          fails = 0;
	int          checked = 0;
	logic [8:0]  seen = '0;

	function automatic atoi_t atoi_step(atoi_t s, logic [7:0] ch);
		atoi_t       r;
		logic        is_dig;
		logic [7:0]  d;
		logic [35:0] t;
		r = s;
		is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
		d = ch - CH_ZERO;
		t = 36'(s.mag) * 36'd10 + 36'(d);
		case (s.phase)
			PH_SKIP: begin
				if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
					r = s;
				end else if (ch == CH_PLUS) begin
					r.phase = PH_DIGITS;
				end else if (ch == CH_MINUS) begin
					r.phase = PH_DIGITS;
					r.neg = 1'b1;
				end else if (is_dig) begin
					r.phase = PH_DIGITS;
					r.mag = 32'(d);
				end else begin
					r.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_dig) begin
					r.mag = (t > 36'(MAG_CAP)) ? MAG_CAP : t[31:0];
				end else begin
					r.phase = PH_DONE;
				end
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	function automatic longint atoi_value(atoi_t s);
		longint v;
		if (s.neg) begin
			v = -longint'(s.mag);
		end else if (s.mag > POS_MAX) begin
			v = longint'(POS_MAX);
		end else begin
			v = longint'(s.mag);
		end
		return v;
	endfunction

	function void start_new_line();
		line_len = 0;
		text_len = 0;
		text_done = 1'b0;
		cr_held = 1'b0;
		alive = ALL_ALIVE;
		motor_ch = CH_NUL;
		speed_num = '{neg: 1'b0, phase: PH_SKIP, mag: 32'd0};
		angle_num = '{neg: 1'b0, phase: PH_SKIP, mag: 32'd0};
	endfunction

	function void feed_text(logic [7:0] ch);
		int unsigned idx;
		if (text_done) return;
		if (ch == CH_NUL) begin
			text_done = 1'b1;
			return;
		end
		idx = text_len;
		text_len++;
		for (int k = KW_START; k <= KW_HOME; k++) begin
			if (idx < keywords[k].len()) begin
				if (8'(keywords[k][idx]) != ch) alive[k] = 1'b0;
			end else if (k == KW_START || k == KW_STOP) begin
				alive[k] = 1'b0;
			end
		end
		if (idx == 0 && ch != CH_M) alive[KW_M] = 1'b0;
		if (idx == 1) motor_ch = ch;
		if (idx >= 3) angle_num = atoi_step(angle_num, ch);
		if (idx >= keywords[KW_SET].len()) speed_num = atoi_step(speed_num, ch);
	endfunction

	function void take_byte(logic [7:0] ch);
		command_t   c;
		longint     a;
		longint     st;
		logic [7:0] d;
		int unsigned n;
		c.kind = KIND_UNKNOWN;
		c.motor = 2'd0;
		c.value = 32'd0;
		c.steps = 32'd0;
		if (ch != CH_LF) begin
			if (line_len >= LINE_MAX_DEF - 1) begin
				start_new_line();
				c.kind = KIND_OVERFLOW;
				expected_commands.push_back(c);
			end else begin
				if (cr_held) feed_text(CH_CR);
				cr_held = 1'b0;
				line_len++;
				if (ch == CH_CR) cr_held = 1'b1;
				else feed_text(ch);
			end
			return;
		end
		n = text_len;
		if (alive[KW_START] && n == keywords[KW_START].len()) begin
			c.kind = KIND_START;
		end else if (alive[KW_STOP] && n == keywords[KW_STOP].len()) begin
			c.kind = KIND_STOP;
		end else if (alive[KW_SET] && n >= keywords[KW_SET].len()) begin
			c.kind = KIND_SET_SPEED;
			c.value = 32'(atoi_value(speed_num));
		end else if (alive[KW_INFO] && n >= keywords[KW_INFO].len()) begin
			c.kind = KIND_INFO;
		end else if (alive[KW_HOME] && n >= keywords[KW_HOME].len()) begin
			c.kind = KIND_HOME;
		end else if (alive[KW_M] && n >= 1) begin
			if (motor_ch >= CH_ONE && motor_ch <= CH_THREE) begin
				a = atoi_value(angle_num);
				st = (a * 200) / 360;
				d = motor_ch - CH_ZERO;
				c.kind = KIND_MOVE;
				c.motor = d[1:0];
				c.value = 32'(a);
				c.steps = 32'(st);
			end else begin
				c.kind = KIND_BAD_MOTOR;
			end
		end
		start_new_line();
		expected_commands.push_back(c);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		command_t    exp_c;
		logic [3:0]  got_kind;
		logic [1:0]  got_motor;
		logic [31:0] got_value;
		logic [31:0] got_steps;
		logic [1:0]  got_pad;
		if (!arst_n) begin
			start_new_line();
			expected_commands.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_kind = m_axis_tdata[3:0];
				got_motor = m_axis_tdata[5:4];
				got_value = m_axis_tdata[37:6];
				got_steps = m_axis_tdata[69:38];
				got_pad = m_axis_tdata[71:70];
				if (expected_commands.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("unexpected command transfer, data %h", m_axis_tdata);
				end else begin
					exp_c = expected_commands.pop_front();
					checked++;
					seen[exp_c.kind] = 1'b1;
					if (got_kind != exp_c.kind || got_motor != exp_c.motor ||
					    got_value != exp_c.value || got_steps != exp_c.steps ||
					    got_pad != 2'd0) begin
						fails++;
						if (fails <= REPORT_MAX) begin
							$display("command mismatch: expected kind %0d motor %0d value %0d steps %0d",
								exp_c.kind, exp_c.motor, $signed(exp_c.value),
								$signed(exp_c.steps));
							$display("                  actual   kind %0d motor %0d value %0d steps %0d pad %0d",
								got_kind, got_motor, $signed(got_value),
								$signed(got_steps), got_pad);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
		end
		fail_count <= fails;
		pending <= expected_commands.size();
		results_seen <= checked;
		kinds_seen <= seen;
	end

endmodule

FILE: tb/tb_ascii_motor_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_ascii_motor_command_decoder_unit
// Feeds text lines into the motor command decoder: a few fixed lines, then
// random commands, near misses, noise, NUL and CR cases and overlong lines,
// with random gaps and stalls on both channels; the checker does the scoring
// ----------------------------------------------------------------------------
module tb_ascii_motor_command_decoder_unit;
	import amcd_pkg::*;

	localparam int ITEMS = 1100;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int PAUSE_AT = 650;
	localparam int CALM_AFTER = 950;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_LINE = 97;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	int          fail_count;
	int          pending;
	int          results_seen;
	logic [8:0]  kinds_seen;

	logic [7:0]  line_buf [$];
	int          sent = 0;
	int          idle_cycles = 0;
	logic        gaps_on = 1'b1;
	logic        stall_on = 1'b1;
	logic        hold_req = 1'b0;

	always #5 clk = ~clk;

	ascii_motor_command_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ascii_motor_command_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen),
		.kinds_seen    (kinds_seen)
	);

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
	endtask

	// random bytes, never a line feed
	task automatic put_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_LF) b = 8'($urandom_range(0, 1) ? CH_NUL : 8'hF5);
			line_buf.push_back(b);
		end
	endtask

	task automatic end_line(input int crs);
		repeat (crs) line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endtask

	task automatic put_number();
		string extremes [6] = '{"2147483647", "2147483648", "2147483649",
			"4294967296", "99999999999999", "0"};
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 5))
				0: line_buf.push_back(8'd9);
				1: line_buf.push_back(8'd11);
				2: line_buf.push_back(8'd12);
				3: line_buf.push_back(CH_CR);
				default: line_buf.push_back(CH_SPACE);
			endcase
		end
		case ($urandom_range(0, 3))
			0: line_buf.push_back(CH_PLUS);
			1: line_buf.push_back(CH_MINUS);
			default: ;
		endcase
		if ($urandom_range(0, 5) == 0) begin
			put_text(extremes[$urandom_range(0, 5)]);
		end else begin
			repeat ($urandom_range(0, $urandom_range(0, 1) ? 4 : 11))
				line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 3));
	endtask

	task automatic build_line(input int pick);
		string keys [5] = '{"START", "STOP", "SET SPEED ", "INFO", "HOME"};
		string s;
		int    r;
		int    cut;
		int    mode;
		int    len;
		line_buf.delete();
		r = (pick >= 0) ? pick : $urandom_range(0, 99);
		if (r < 10) begin
			put_text(keys[$urandom_range(0, 1)]);
			if ($urandom_range(0, 3) == 0) put_noise(1);
		end else if (r < 25) begin
			case ($urandom_range(0, 7))
				0: put_text("SET SPEED");
				1: put_text("SET SPEEDX");
				default: put_text("SET SPEED ");
			endcase
			put_number();
		end else if (r < 35) begin
			put_text(keys[$urandom_range(3, 4)]);
			put_noise($urandom_range(0, 4));
		end else if (r < 65) begin
			line_buf.push_back(CH_M);
			case ($urandom_range(0, 9))
				0: put_noise(1);
				1: ;
				default: line_buf.push_back(CH_ONE + 8'($urandom_range(0, 2)));
			endcase
			if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_SPACE);
			else put_noise($urandom_range(0, 1));
			put_number();
		end else if (r < 75) begin
			// near miss: keyword cut short or with one character changed
			s = keys[$urandom_range(0, 4)];
			cut = $urandom_range(0, s.len() - 1);
			mode = $urandom_range(0, 1);
			for (int i = 0; i < s.len(); i++) begin
				if (i == cut && mode == 0) break;
				line_buf.push_back(i == cut ? 8'(s[i]) ^ 8'h01 : 8'(s[i]));
			end
		end else if (r < 90) begin
			put_noise($urandom_range(0, 12));
		end else if (r < LONG_LINE) begin
			// text cut off by a nul byte
			if ($urandom_range(0, 1)) begin
				put_text(keys[$urandom_range(0, 4)]);
			end else begin
				put_text("M2 ");
				put_number();
			end
			line_buf.push_back(CH_NUL);
			put_noise($urandom_range(0, 4));
		end else begin
			if ($urandom_range(0, 1)) put_text(keys[$urandom_range(0, 4)]);
			else put_text("M1 ");
			len = $urandom_range(0, 1) ? $urandom_range(114, 124) : $urandom_range(100, 140);
			repeat (len) begin
				if ($urandom_range(0, 7) == 0) put_noise(1);
				else line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end
		case ($urandom_range(0, 19))
			14, 15, 16: end_line(1);
			17, 18: end_line(2);
			19: ;
			default: end_line(0);
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	// receiver side
	initial begin
		m_axis_tready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		string d_text [9];
		int    d_cr [9];
		logic  held;
		logic  paused;
		d_text = '{"START", "STOP", "", "M", "M3-9", "M0", "INFO",
			"SET SPEED 7", "HOME"};
		d_cr = '{0, 1, 0, 0, 0, 0, 2, 0, 0};
		held = 1'b0;
		paused = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 9; i++) begin
			put_text(d_text[i]);
			if (i == 8) begin
				// nul ends the text, the rest is not parsed
				line_buf.push_back(CH_NUL);
				put_text("!");
			end
			end_line(d_cr[i]);
			send_line();
		end

		build_line(LONG_LINE);
		send_line();
		while (sent < ITEMS) begin
			if (sent >= CALM_AFTER) begin
				gaps_on = 1'b0;
				stall_on = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				gaps_on = $urandom_range(0, 2) != 0;
				stall_on = $urandom_range(0, 2) != 0;
			end
			if (!held && sent >= HOLD_AT) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && sent >= PAUSE_AT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				paused = 1'b1;
			end
			build_line(-1);
			send_line();
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes: fixed lines, random commands, near misses, noise, nul bytes,",
			sent);
		$display("cr handling and overlong lines; %0d commands checked, kinds seen %b",
			results_seen, kinds_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: ascii_motor_command_decoder_unit.f
+incdir+rtl/core
rtl/core/amcd_pkg.sv
rtl/core/ascii_motor_command_decoder_unit.sv
tb/ascii_motor_command_checker.sv
tb/tb_ascii_motor_command_decoder_unit.sv
